// File: hw/rtl/u2hk_pkg.sv
// Types, key usage constants and byte-to-keystroke lookup functions.
`default_nettype none
package u2hk_pkg;

  // HID usage ids
  localparam logic [7:0] KEY_A      = 8'h04;
  localparam logic [7:0] KEY_E      = 8'h08;
  localparam logic [7:0] KEY_I      = 8'h0C;
  localparam logic [7:0] KEY_O      = 8'h12;
  localparam logic [7:0] KEY_U      = 8'h18;
  localparam logic [7:0] KEY_Q      = 8'h14;
  localparam logic [7:0] KEY_W      = 8'h1A;
  localparam logic [7:0] KEY_1      = 8'h1E;
  localparam logic [7:0] KEY_0      = 8'h27;
  localparam logic [7:0] KEY_ENTER  = 8'h28;
  localparam logic [7:0] KEY_TAB    = 8'h2B;
  localparam logic [7:0] KEY_SPACE  = 8'h2C;
  localparam logic [7:0] KEY_MINUS  = 8'h2D;
  localparam logic [7:0] KEY_EQUAL  = 8'h2E;
  localparam logic [7:0] KEY_BRL    = 8'h2F;
  localparam logic [7:0] KEY_BRR    = 8'h30;
  localparam logic [7:0] KEY_BSL    = 8'h31;
  localparam logic [7:0] KEY_SEMI   = 8'h33;
  localparam logic [7:0] KEY_APOS   = 8'h34;
  localparam logic [7:0] KEY_COMMA  = 8'h36;
  localparam logic [7:0] KEY_PERIOD = 8'h37;
  localparam logic [7:0] KEY_SLASH  = 8'h38;
  localparam logic [7:0] KEY_NONE   = 8'h00;

  // HID modifier bits
  localparam logic [7:0] MOD_NONE  = 8'h00;
  localparam logic [7:0] MOD_SHIFT = 8'h02;
  localparam logic [7:0] MOD_RALT  = 8'h40;

  // UTF-8 lead byte detection and the one lead byte with known pairs
  localparam logic [7:0] LEAD_MASK  = 8'hE0;
  localparam logic [7:0] LEAD_MATCH = 8'hC0;
  localparam logic [7:0] LEAD_C3    = 8'hC3;

  // Trail bytes after the 0xC3 lead
  localparam logic [7:0] TRAIL_C_CED_LO = 8'hA7;
  localparam logic [7:0] TRAIL_C_CED_UP = 8'h87;
  localparam logic [7:0] TRAIL_A_ACUTE  = 8'hA1;
  localparam logic [7:0] TRAIL_E_ACUTE  = 8'hA9;
  localparam logic [7:0] TRAIL_I_ACUTE  = 8'hAD;
  localparam logic [7:0] TRAIL_O_ACUTE  = 8'hB3;
  localparam logic [7:0] TRAIL_U_ACUTE  = 8'hBA;
  localparam logic [7:0] TRAIL_A_CIRC   = 8'hA2;
  localparam logic [7:0] TRAIL_E_CIRC   = 8'hAA;
  localparam logic [7:0] TRAIL_O_CIRC   = 8'hB4;
  localparam logic [7:0] TRAIL_A_TILDE  = 8'hA3;
  localparam logic [7:0] TRAIL_O_TILDE  = 8'hB5;
  localparam logic [7:0] TRAIL_A_GRAVE  = 8'hA0;

  // ASCII characters with their own handling
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_DIG_1 = 8'h31;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  typedef struct packed {
    logic [7:0] key_code;
    logic [7:0] modifier_bits;
  } key_t;

  typedef struct packed {
    key_t       key;
    logic       last_of_run;
  } press_t;

  // Up to two presses for one input byte
  typedef struct packed {
    logic [1:0] count;
    key_t       first;
    key_t       second;
  } decode_t;

  function automatic key_t mk_key(logic [7:0] code, logic [7:0] modbits);
    key_t k;
    k.key_code      = code;
    k.modifier_bits = modbits;
    return k;
  endfunction

  function automatic decode_t one_press(logic [7:0] code, logic [7:0] modbits);
    decode_t d;
    d.count  = 2'd1;
    d.first  = mk_key(code, modbits);
    d.second = mk_key(KEY_NONE, MOD_NONE);
    return d;
  endfunction

  function automatic decode_t two_press(logic [7:0] c0, logic [7:0] m0,
                                        logic [7:0] c1);
    decode_t d;
    d.count  = 2'd2;
    d.first  = mk_key(c0, m0);
    d.second = mk_key(c1, MOD_NONE);
    return d;
  endfunction

  function automatic decode_t no_press();
    decode_t d;
    d.count  = 2'd0;
    d.first  = mk_key(KEY_NONE, MOD_NONE);
    d.second = mk_key(KEY_NONE, MOD_NONE);
    return d;
  endfunction

  // Trail byte after a 0xC3 lead
  function automatic decode_t pair_map(logic [7:0] trail);
    decode_t d;
    case (trail)
      TRAIL_C_CED_LO: d = one_press(KEY_SEMI, MOD_NONE);
      TRAIL_C_CED_UP: d = one_press(KEY_SEMI, MOD_SHIFT);
      TRAIL_A_ACUTE:  d = two_press(KEY_BRL, MOD_NONE, KEY_A);
      TRAIL_E_ACUTE:  d = two_press(KEY_BRL, MOD_NONE, KEY_E);
      TRAIL_I_ACUTE:  d = two_press(KEY_BRL, MOD_NONE, KEY_I);
      TRAIL_O_ACUTE:  d = two_press(KEY_BRL, MOD_NONE, KEY_O);
      TRAIL_U_ACUTE:  d = two_press(KEY_BRL, MOD_NONE, KEY_U);
      TRAIL_A_CIRC:   d = two_press(KEY_APOS, MOD_SHIFT, KEY_A);
      TRAIL_E_CIRC:   d = two_press(KEY_APOS, MOD_SHIFT, KEY_E);
      TRAIL_O_CIRC:   d = two_press(KEY_APOS, MOD_SHIFT, KEY_O);
      TRAIL_A_TILDE:  d = two_press(KEY_APOS, MOD_NONE, KEY_A);
      TRAIL_O_TILDE:  d = two_press(KEY_APOS, MOD_NONE, KEY_O);
      TRAIL_A_GRAVE:  d = two_press(KEY_BRL, MOD_SHIFT, KEY_A);
      default:        d = no_press();
    endcase
    return d;
  endfunction

  // Byte typed on its own
  function automatic decode_t single_map(logic [7:0] c);
    decode_t    d;
    logic [7:0] code;
    logic [7:0] modbits;
    code    = KEY_NONE;
    modbits = MOD_NONE;
    if (c >= CH_LC_A && c <= CH_LC_Z) begin
      code = KEY_A + (c - CH_LC_A);
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      code    = KEY_A + (c - CH_UC_A);
      modbits = MOD_SHIFT;
    end else if (c >= CH_DIG_1 && c <= CH_DIG_9) begin
      code = KEY_1 + (c - CH_DIG_1);
    end else begin
      case (c)
        8'h30: code = KEY_0;                                   // '0'
        8'h21: begin code = KEY_1;        modbits = MOD_SHIFT; end // '!'
        8'h40: begin code = KEY_1 + 8'd1; modbits = MOD_SHIFT; end // '@'
        8'h23: begin code = KEY_1 + 8'd2; modbits = MOD_SHIFT; end // '#'
        8'h24: begin code = KEY_1 + 8'd3; modbits = MOD_SHIFT; end // '$'
        8'h25: begin code = KEY_1 + 8'd4; modbits = MOD_SHIFT; end // '%'
        8'h26: begin code = KEY_1 + 8'd6; modbits = MOD_SHIFT; end // '&'
        8'h2A: begin code = KEY_1 + 8'd7; modbits = MOD_SHIFT; end // '*'
        8'h28: begin code = KEY_1 + 8'd8; modbits = MOD_SHIFT; end // '('
        8'h29: begin code = KEY_0;        modbits = MOD_SHIFT; end // ')'
        8'h20: code = KEY_SPACE;
        8'h0A: code = KEY_ENTER;
        8'h09: code = KEY_TAB;
        8'h2D: code = KEY_MINUS;
        8'h3D: code = KEY_EQUAL;
        8'h5F: begin code = KEY_MINUS; modbits = MOD_SHIFT; end // '_'
        8'h2B: begin code = KEY_EQUAL; modbits = MOD_SHIFT; end // '+'
        8'h2E: code = KEY_PERIOD;
        8'h2C: code = KEY_COMMA;
        8'h3B: code = KEY_SLASH;                               // ';'
        8'h3A: begin code = KEY_SLASH; modbits = MOD_SHIFT; end // ':'
        8'h2F: begin code = KEY_Q;     modbits = MOD_RALT;  end // '/'
        8'h3F: begin code = KEY_W;     modbits = MOD_RALT;  end // '?'
        8'h5B: begin code = KEY_BRL;   modbits = MOD_RALT;  end // '['
        8'h7B: begin code = KEY_BRL;   modbits = MOD_RALT | MOD_SHIFT; end // '{'
        8'h5D: begin code = KEY_BRR;   modbits = MOD_RALT;  end // ']'
        8'h7D: begin code = KEY_BRR;   modbits = MOD_RALT | MOD_SHIFT; end // '}'
        8'h5C: code = KEY_BSL;                                 // backslash
        8'h7C: begin code = KEY_BSL;   modbits = MOD_SHIFT; end // '|'
        default: code = KEY_NONE;
      endcase
    end
    if (c == CH_APOS) begin
      d = two_press(KEY_BRL, MOD_NONE, KEY_SPACE);
    end else if (c == CH_QUOTE) begin
      d = one_press(KEY_BRL, MOD_SHIFT);
    end else if (code == KEY_NONE) begin
      d = no_press();
    end else begin
      d = one_press(code, modbits);
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/u2hk_if.sv
// Valid/ready channel interfaces for text bytes in and key presses out.
`default_nettype none
interface u2hk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       string_end;

  modport source (output valid, output char_byte, output string_end, input ready);
  modport sink   (input valid, input char_byte, input string_end, output ready);
endinterface

interface u2hk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic [7:0] modifier_bits;
  logic       last_of_run;

  modport source (output valid, output key_code, output modifier_bits,
                  output last_of_run, input ready);
  modport sink   (input valid, input key_code, input modifier_bits,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/utf8_to_hid_keystroke_abnt2.sv
// Top level: text byte stream to ABNT2 HID key presses.
//
//   channel | dir | payload                                   | beat
//   in_i    | in  | char_byte[7:0], string_end                | one text byte
//   out_o   | out | key_code[7:0], modifier_bits[7:0], last_of_run | one key press
//
// A byte is registered on accept, then decoded from that register into the output
// register and, for two-press runs, a second-press register, once the output
// register is free and no second press is pending. Bytes giving zero or one press
// flow at one per cycle while out_o is ready; a two-press byte holds the input
// while the second press drains through the single output register. Backpressure on
// out_o stalls the decode stage and then in_i. Reset clears the held lead byte
// and all valid flags.
`default_nettype none
module utf8_to_hid_keystroke_abnt2 (
  input  wire             clk_i,
  input  wire             rst_ni,
  u2hk_in_if.sink         in_i,
  u2hk_out_if.source      out_o
);

  // input stage
  logic       s0_valid_q;
  logic [7:0] s0_char_q;
  logic       s0_end_q;

  // held UTF-8 lead byte
  logic       held_valid_q, held_valid_d;
  logic [7:0] held_q, held_d;

  // result stage
  logic                 out_valid_q;
  u2hk_pkg::press_t     out_q;
  logic                 sec_valid_q;
  u2hk_pkg::press_t     sec_q;

  u2hk_pkg::decode_t    pair_dec, single_dec, dec;
  logic                 pair_hit, is_lead;
  logic                 out_free, s0_adv, sec_move, in_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign sec_move = sec_valid_q && out_free;
  assign s0_adv   = s0_valid_q && !sec_valid_q && out_free;
  assign in_i.ready = !s0_valid_q || s0_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    pair_dec   = u2hk_pkg::pair_map(s0_char_q);
    single_dec = u2hk_pkg::single_map(s0_char_q);
    pair_hit   = held_valid_q && (held_q == u2hk_pkg::LEAD_C3) && (pair_dec.count != 2'd0);
    is_lead    = (s0_char_q & u2hk_pkg::LEAD_MASK) == u2hk_pkg::LEAD_MATCH;
    if (pair_hit) begin
      dec = pair_dec;
    end else if (is_lead) begin
      dec = u2hk_pkg::no_press();
    end else begin
      dec = single_dec;
    end
  end

  // A held lead is consumed by any next byte; a new lead is held unless the
  // string ends on it.
  always_comb begin
    held_valid_d = held_valid_q;
    held_d       = held_q;
    if (s0_adv) begin
      held_valid_d = 1'b0;
      held_d       = '0;
      if (!pair_hit && is_lead && !s0_end_q) begin
        held_valid_d = 1'b1;
        held_d       = s0_char_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q   <= 1'b0;
      held_valid_q <= 1'b0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
      sec_valid_q  <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
      if (in_fire) begin
        s0_valid_q <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_q <= 1'b0;
      end
      if (sec_move) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else if (s0_adv) begin
        out_valid_q <= dec.count != 2'd0;
        sec_valid_q <= dec.count == 2'd2;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_char_q <= in_i.char_byte;
      s0_end_q  <= in_i.string_end;
    end
    if (sec_move) begin
      out_q <= sec_q;
    end else if (s0_adv) begin
      out_q.key         <= dec.first;
      out_q.last_of_run <= dec.count == 2'd1;
      sec_q.key         <= dec.second;
      sec_q.last_of_run <= 1'b1;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.key_code      = out_q.key.key_code;
  assign out_o.modifier_bits = out_q.key.modifier_bits;
  assign out_o.last_of_run   = out_q.last_of_run;

endmodule
`default_nettype wire

// File: hw/rtl/u2hk_checker.sv
// Port-level checker for the keystroke encoder, bound to the top level.
`default_nettype none
module u2hk_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [7:0] key_code_i,
  input wire [7:0] modifier_bits_i,
  input wire       last_of_run_i
);

  // a stalled press keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(key_code_i)
      && $stable(modifier_bits_i) && $stable(last_of_run_i))
    else $error("stalled press changed or dropped");

  // only dead keys open a two-press run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |->
      key_code_i == u2hk_pkg::KEY_BRL || key_code_i == u2hk_pkg::KEY_APOS)
    else $error("first of two presses is not a dead key");

  // the press after a run opener closes the run and carries no modifier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i |=>
      out_valid_i && last_of_run_i && modifier_bits_i == u2hk_pkg::MOD_NONE)
    else $error("second press of a run missing or malformed");

  // only shift and right alt ever appear, and never a null key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> key_code_i != u2hk_pkg::KEY_NONE
      && (modifier_bits_i & ~(u2hk_pkg::MOD_SHIFT | u2hk_pkg::MOD_RALT)) == 8'h00)
    else $error("press with null key or unexpected modifier");

endmodule

bind utf8_to_hid_keystroke_abnt2 u2hk_checker u_u2hk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .key_code_i      (out_o.key_code),
  .modifier_bits_i (out_o.modifier_bits),
  .last_of_run_i   (out_o.last_of_run)
);
`default_nettype wire
